[rtl/spq_pkg.sv]
// Package with the shared types, constants and codes of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_OFFER  = 3'd0;
  localparam logic [2:0] MODE_AT     = 3'd1;
  localparam logic [2:0] MODE_REMVAL = 3'd2;
  localparam logic [2:0] MODE_REMAT  = 3'd3;
  localparam logic [2:0] MODE_SIZE   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] key;
    logic [31:0] item;
    logic [7:0]  position;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_item;
    logic [15:0] out_key;
    logic [4:0]  tally;
  } spq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WRITE,
    S_DONE
  } spq_state_t;

endpackage

[rtl/spq_ram.sv]
// Generic single-port-write, one-read memory with a registered read.
`timescale 1ns / 1ps
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: sequencer over one entry memory.
//
// Usage: an operation beat enters on in_valid/in_stall with payload "in", and
// exactly one result beat leaves on out_valid/out_stall with payload "out".
// One operation is worked at a time. Each operation walks the held entries
// through the entry memory (one read per cycle, registered read), moving
// entries one place up for an insert, one place down for a removal at index,
// and down past removed entries for compaction. Read, remove at index and
// remove by value walk the held entries; an offer walks them and then writes
// the last displaced entry, or the new one, at the end. Size, unknown modes,
// an offer into a full queue and an index not present skip the walk, as does
// a remove by value from an empty queue. The next beat can be taken as soon
// as the result goes valid: the sequencer returns to idle as it is loaded.
// Reset clears the entry count, so the queue is empty; memory contents are
// not cleared and are never read before being written.
// While the receiver stalls, the result holds in the output register. The
// next operation can still be taken and worked; it waits at completion until
// the output register is free.
`timescale 1ns / 1ps
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + 32;

  spq_state_t state, state_next;

  // Operation registers.
  logic [2:0]          op_mode;
  logic [KEY_BITS-1:0] op_key;
  logic [31:0]         op_item;
  logic [7:0]          op_pos;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_idx;   // next entry to read
  logic [CW-1:0]       wr_idx;   // next compaction target
  logic [CW-1:0]       removed;
  logic                found;    // insert point met
  logic [CW-1:0]       ins_at;
  logic [EW-1:0]       carry;    // entry displaced by insert, or entry read by index
  logic [CW-1:0]       cur_idx;  // index of rdata
  logic                accept;
  logic                out_free; // output register can take a new beat
  logic                pos_out;  // index not below the entry count
  spq_out_t            res;

  // Memory port signals.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  spq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign raddr    = rd_idx[AW-1:0];
  assign pos_out  = {{(8 > CW ? 0 : CW - 8){1'b0}}, op_pos} >=
                    {{(CW > 8 ? 0 : 8 - CW){1'b0}}, count};

  logic [KEY_BITS-1:0] r_key;
  logic [31:0]         r_item;
  assign r_key  = rdata[EW-1:32];
  assign r_item = rdata[31:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_SCAN;
        if (op_mode == MODE_OFFER && count == CW'(DEPTH)) begin
          state_next = S_DONE;
        end else if (op_mode == MODE_OFFER && count == '0) begin
          state_next = S_WRITE;
        end else if (op_mode == MODE_REMVAL && count == '0) begin
          state_next = S_DONE;
        end else if ((op_mode == MODE_AT || op_mode == MODE_REMAT) && pos_out) begin
          state_next = S_DONE;
        end else if (op_mode == MODE_SIZE || op_mode > MODE_SIZE) begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (cur_idx + 1'b1 >= count) begin
          state_next = (op_mode == MODE_OFFER) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory write control.
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx[AW-1:0];
    wdata = rdata;
    if (state == S_SCAN) begin
      unique case (op_mode)
        MODE_OFFER: begin
          if (found || r_key > op_key) begin
            we    = 1'b1;
            wdata = found ? carry : {op_key, op_item};
          end
        end
        MODE_REMVAL: begin
          we    = (r_item != op_item);
          waddr = wr_idx[AW-1:0];
        end
        MODE_REMAT: begin
          we    = (cur_idx > CW'(op_pos));
          waddr = AW'(cur_idx - 1'b1);
        end
        default: we = 1'b0;
      endcase
    end else if (state == S_WRITE) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = found ? carry : {op_key, op_item};
    end
  end

  // Result beat of the finished operation.
  always_comb begin
    res       = '0;
    res.tally = 5'(count);
    unique case (op_mode) inside
      MODE_OFFER: begin
        if (ins_at == CW'(DEPTH)) begin
          // The queue was full, so nothing was stored.
          res.status = ST_FULL;
          res.tally  = '0;
        end else begin
          res.tally = 5'(ins_at);
        end
      end
      MODE_AT, MODE_REMAT: begin
        if (pos_out) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_item = carry[31:0];
          res.out_key  = 16'(carry[EW-1:32]);
          if (op_mode == MODE_REMAT) begin
            res.tally = 5'(count - 1'b1);
          end
        end
      end
      MODE_REMVAL: res.tally = 5'(removed);
      MODE_SIZE: res.status = ST_OK;
      default: res.status = ST_EMPTY;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode <= in.mode;
            op_key  <= in.key[KEY_BITS-1:0];
            op_item <= in.item;
            op_pos  <= in.position;
            rd_idx  <= '0;
            wr_idx  <= '0;
            removed <= '0;
            found   <= 1'b0;
            ins_at  <= '0;
          end
        end
        S_READ: begin
          cur_idx <= rd_idx;
          rd_idx  <= rd_idx + 1'b1;
          ins_at  <= count;
        end
        S_SCAN: begin
          cur_idx <= rd_idx;
          rd_idx  <= rd_idx + 1'b1;
          if (op_mode == MODE_OFFER) begin
            if (found || r_key > op_key) begin
              carry <= rdata;
              if (!found) begin
                ins_at <= cur_idx;
              end
              found <= 1'b1;
            end
          end
          if (op_mode == MODE_REMVAL) begin
            if (r_item != op_item) begin
              wr_idx <= wr_idx + 1'b1;
            end else begin
              removed <= removed + 1'b1;
            end
          end
          if ((op_mode == MODE_AT || op_mode == MODE_REMAT) && cur_idx == CW'(op_pos)) begin
            carry <= rdata;
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
        end
        S_DONE: begin
          // The result and the count update of a removal wait for a free output register.
          if (out_free) begin
            out <= res;
            if (op_mode == MODE_REMAT && !pos_out) begin
              count <= count - 1'b1;
            end else if (op_mode == MODE_REMVAL) begin
              count <= count - removed;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The entry count never exceeds the queue depth.
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count above depth");
  // A result beat is produced only out of the completion state.
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without completion");
  // A stalled result beat stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out))
    else $error("stalled result changed");
`endif

endmodule

[sim/sorted_priority_queue_core_test.sv]
// Testbench for the sorted priority queue: random and directed operations checked against a predictor.
`timescale 1ns / 1ps
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Mode codes outside the defined set.
  localparam logic [2:0] MODE_BAD_FIRST = 3'd5;
  localparam logic [2:0] MODE_BAD_LAST  = 3'd7;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  spq_in_t  in;
  logic     out_valid;
  logic     out_stall;
  spq_out_t out;

  sorted_priority_queue_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in(in),
    .out_valid(out_valid), .out_stall(out_stall), .out(out)
  );

  // Predictor state: a sorted copy of the held entries.
  logic [15:0] model_keys[QDEPTH];
  logic [31:0] model_items[QDEPTH];
  int          model_count;

  spq_in_t  pending_ops[$];
  spq_out_t expected_results[$];
  int       errors;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  bit       stimulus_done;
  int       quiet_cycles;
  logic     in_taken;

  // Apply one operation to the predictor and return the result it must give.
  function automatic spq_out_t apply_op(spq_in_t op);
    spq_out_t r;
    int at;
    int w;
    int removed;
    r = '0;
    case (op.mode) inside
      MODE_OFFER: begin
        if (model_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          while (at < model_count && model_keys[at] <= op.key) at++;
          for (int i = model_count; i > at; i--) begin
            model_keys[i] = model_keys[i-1];
            model_items[i] = model_items[i-1];
          end
          model_keys[at] = op.key;
          model_items[at] = op.item;
          model_count++;
          r.tally = 5'(at);
        end
      end
      MODE_AT, MODE_REMAT: begin
        if (op.position < model_count) begin
          r.out_item = model_items[op.position];
          r.out_key = model_keys[op.position];
          if (op.mode == MODE_REMAT) begin
            for (int j = op.position; j + 1 < model_count; j++) begin
              model_keys[j] = model_keys[j+1];
              model_items[j] = model_items[j+1];
            end
            model_count--;
          end
        end else begin
          r.status = ST_EMPTY;
        end
        r.tally = 5'(model_count);
      end
      MODE_REMVAL: begin
        w = 0;
        removed = 0;
        for (int i = 0; i < model_count; i++) begin
          if (model_items[i] == op.item) begin
            removed++;
          end else begin
            model_keys[w] = model_keys[i];
            model_items[w] = model_items[i];
            w++;
          end
        end
        model_count = w;
        r.tally = 5'(removed);
      end
      MODE_SIZE: r.tally = 5'(model_count);
      default: begin
        r.status = ST_EMPTY;
        r.tally = 5'(model_count);
      end
    endcase
    return r;
  endfunction

  function automatic spq_in_t make_op(logic [2:0] mode, logic [15:0] key,
                                      logic [31:0] item, logic [7:0] position);
    spq_in_t op;
    op.mode = mode;
    op.key = key;
    op.item = item;
    op.position = position;
    return op;
  endfunction

  // Random operation biased toward small positions and a few shared handles.
  function automatic spq_in_t random_op();
    spq_in_t op;
    int pick;
    op = make_op(3'($urandom_range(0, 7)), 16'($urandom), $urandom, 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 40) op.mode = MODE_OFFER;
    else if (pick < 55) op.mode = MODE_AT;
    else if (pick < 65) op.mode = MODE_REMVAL;
    else if (pick < 85) op.mode = MODE_REMAT;
    else if (pick < 92) op.mode = MODE_SIZE;
    if ($urandom_range(0, 3) != 0) op.key = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 2) != 0) op.item = $urandom_range(0, 9);
    if ($urandom_range(0, 4) != 0) op.position = 8'($urandom_range(0, 17));
    return op;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Records whether the offered beat was taken at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
    end
  end

  // Driver: takes the next operation from the pending queue, changes at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) void'(pending_ops.pop_front());
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in <= pending_ops[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off when asked.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predicts on each accepted operation and checks each accepted result.
  always @(posedge clk) begin
    spq_out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out.status !== want.status || out.out_item !== want.out_item ||
              out.out_key !== want.out_key || out.tally !== want.tally) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if (!stimulus_done && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_priority_queue_core test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) pending_ops.push_back(random_op());
    wait_drained();
  endtask

  initial begin
    errors = 0;
    model_count = 0;
    quiet_cycles = 0;
    stimulus_done = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queue cases, extremes, equal keys, full queue, unknown modes.
    pending_ops.push_back(make_op(MODE_AT, 16'h0, 32'h0, 8'h0));
    pending_ops.push_back(make_op(MODE_REMAT, 16'h0, 32'h0, 8'hFF));
    pending_ops.push_back(make_op(MODE_REMVAL, 16'h0, 32'hFFFFFFFF, 8'h0));
    pending_ops.push_back(make_op(MODE_OFFER, 16'hFFFF, 32'hFFFFFFFF, 8'hFF));
    pending_ops.push_back(make_op(MODE_OFFER, 16'h0, 32'h0, 8'h0));
    pending_ops.push_back(make_op(MODE_OFFER, 16'h0, 32'h5, 8'h0));
    for (int i = 0; i < 14; i++)
      pending_ops.push_back(make_op(MODE_OFFER, 16'h8000, 32'h5, 8'h0));
    pending_ops.push_back(make_op(MODE_BAD_FIRST, 16'h1, 32'h1, 8'h1));
    pending_ops.push_back(make_op(MODE_BAD_LAST, 16'h1, 32'h1, 8'h1));
    pending_ops.push_back(make_op(MODE_SIZE, 16'h0, 32'h0, 8'h0));
    pending_ops.push_back(make_op(MODE_AT, 16'h0, 32'h0, 8'd15));
    pending_ops.push_back(make_op(MODE_AT, 16'h0, 32'h0, 8'd16));
    pending_ops.push_back(make_op(MODE_REMVAL, 16'h0, 32'h5, 8'h0));
    pending_ops.push_back(make_op(MODE_REMAT, 16'h0, 32'h0, 8'h0));
    wait_drained();

    // Long receiver hold-off while operations keep coming.
    hold_cycles = 400;
    run_random(40, 0, 0);

    run_random(170, 6, 66);
    run_random(170, 66, 6);
    run_random(170, 0, 0);

    stimulus_done = 1'b1;
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("sorted_priority_queue_core test passed");
    end else begin
      $display("sorted_priority_queue_core test failed");
    end
    $finish;
  end

endmodule
